// File: sv/u8v_pkg.sv
// Shared types and byte constants for the UTF-8 stream validator.
`default_nettype none

package u8v_pkg;

  // Restriction applied to the byte after a lead byte
  typedef enum logic [2:0] {
    RULE_NONE = 3'd0,
    RULE_E0   = 3'd1,
    RULE_ED   = 3'd2,
    RULE_F0   = 3'd3,
    RULE_F4   = 3'd4
  } rule_t;

  // Input beat kind
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Byte classes
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;
  localparam logic [7:0] LEAD_ED   = 8'hED;

  // Second-byte limits
  localparam logic [7:0] E0_LOW  = 8'hA0;
  localparam logic [7:0] ED_HIGH = 8'h9F;
  localparam logic [7:0] F0_LOW  = 8'h90;
  localparam logic [7:0] F4_HIGH = 8'h8F;

endpackage

`default_nettype wire

// File: sv/utf8_stream_validator.sv
// UTF-8 stream validator: input register, one-pass check, result register.
`default_nettype none

// An accepted beat is decoded from the input register into the result register at out_.
// Throughput: one beat per clock; while a result waits the input register
// can take one more beat, and the input stalls once that register is full too.
// The combinational decode between the two registers sets that rate.
// Reset (synchronous, rst_n low) empties both registers and clears the
// pending count, second-byte rule and sticky error.
module utf8_stream_validator (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  wire  in_action,
  input  wire  [7:0] in_text_byte,
  output logic out_valid,
  input  wire  out_stall,
  output logic out_error_seen,
  output logic out_done_res,
  output logic out_text_valid
);
  import u8v_pkg::*;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_action_r;
  logic [7:0] s1_byte_r;

  // Text state
  logic [1:0] pending_r, pending_nxt;
  rule_t      rule_r, rule_nxt;
  logic       err_r, err_nxt;

  // Result register
  logic out_valid_r, out_valid_nxt;
  logic out_error_seen_r, out_error_seen_nxt;
  logic out_done_res_r, out_done_res_nxt;
  logic out_text_valid_r, out_text_valid_nxt;

  logic in_accept;
  logic s2_free;
  logic s1_adv;
  logic is_cont;
  logic rule_ok;
  logic text_ok;

  // Handshake
  assign s2_free   = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_stall  = s1_valid_r && !s2_free;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_valid_r && out_stall);

  // Byte classification
  assign is_cont = (s1_byte_r & CONT_MASK) == CONT_TAG;

  always_comb begin
    unique case (rule_r)
      RULE_NONE: rule_ok = 1'b1;
      RULE_E0:   rule_ok = s1_byte_r >= E0_LOW;
      RULE_ED:   rule_ok = s1_byte_r <= ED_HIGH;
      RULE_F0:   rule_ok = s1_byte_r >= F0_LOW;
      RULE_F4:   rule_ok = s1_byte_r <= F4_HIGH;
      default:   rule_ok = 1'b1;
    endcase
  end

  assign text_ok = !err_r && (pending_r == 2'd0);

  // Next text state and result
  always_comb begin
    pending_nxt        = pending_r;
    rule_nxt           = rule_r;
    err_nxt            = err_r;
    out_error_seen_nxt = out_error_seen_r;
    out_done_res_nxt   = out_done_res_r;
    out_text_valid_nxt = out_text_valid_r;
    if (s1_adv) begin
      if (s1_action_r == ACT_END) begin
        pending_nxt        = 2'd0;
        rule_nxt           = RULE_NONE;
        err_nxt            = 1'b0;
        out_error_seen_nxt = !text_ok;
        out_done_res_nxt   = 1'b1;
        out_text_valid_nxt = text_ok;
      end else begin
        if (!err_r) begin
          if (pending_r != 2'd0) begin
            // continuation byte expected
            if (!is_cont || !rule_ok) begin
              err_nxt     = 1'b1;
              pending_nxt = 2'd0;
              rule_nxt    = RULE_NONE;
            end else begin
              pending_nxt = pending_r - 2'd1;
              rule_nxt    = RULE_NONE;
            end
          end else if (s1_byte_r == 8'h00) begin
            err_nxt = 1'b1;
          end else if (s1_byte_r <= ASCII_MAX) begin
            // plain ASCII, nothing to track
          end else if (s1_byte_r >= LEAD2_MIN && s1_byte_r <= LEAD2_MAX) begin
            pending_nxt = 2'd1;
            rule_nxt    = RULE_NONE;
          end else if (s1_byte_r >= LEAD3_MIN && s1_byte_r <= LEAD3_MAX) begin
            pending_nxt = 2'd2;
            rule_nxt    = (s1_byte_r == LEAD3_MIN) ? RULE_E0 :
                          (s1_byte_r == LEAD_ED)   ? RULE_ED : RULE_NONE;
          end else if (s1_byte_r >= LEAD4_MIN && s1_byte_r <= LEAD4_MAX) begin
            pending_nxt = 2'd3;
            rule_nxt    = (s1_byte_r == LEAD4_MIN) ? RULE_F0 :
                          (s1_byte_r == LEAD4_MAX) ? RULE_F4 : RULE_NONE;
          end else begin
            err_nxt = 1'b1;
          end
        end
        out_error_seen_nxt = err_nxt;
        out_done_res_nxt   = 1'b0;
        out_text_valid_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pending_r   <= 2'd0;
      rule_r      <= RULE_NONE;
      err_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pending_r   <= pending_nxt;
      rule_r      <= rule_nxt;
      err_r       <= err_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_text_byte;
    end
    out_error_seen_r <= out_error_seen_nxt;
    out_done_res_r   <= out_done_res_nxt;
    out_text_valid_r <= out_text_valid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_error_seen = out_error_seen_r;
  assign out_done_res   = out_done_res_r;
  assign out_text_valid = out_text_valid_r;

  // A second-byte rule only exists right after a 3- or 4-byte lead
  a_rule_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (rule_r != RULE_NONE) |-> (pending_r >= 2'd2))
    else $error("second-byte rule set without a multi-byte lead");

  // Once an error is latched, sequence tracking is parked
  a_err_parks_state: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (pending_r == 2'd0 && rule_r == RULE_NONE))
    else $error("sequence state active after error");

  // Verdict beat: text_valid is the inverse of the error flag
  a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_res_r) |-> (out_text_valid_r == !out_error_seen_r))
    else $error("verdict disagrees with error flag");

  // Byte beats never claim a valid text
  a_byte_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_res_r) |-> !out_text_valid_r)
    else $error("text_valid set on a byte beat");

  // Input only stalls while the input register holds a beat
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire
